// ===== sv/talu_pkg.sv =====
// ----------------------------------------------------------------------------
// talu_pkg
// Operation codes and constants shared by the thumb ALU and its checker.
// ----------------------------------------------------------------------------
package talu_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned OpWidth    = 5;
  localparam int unsigned ShiftWidth = 8;

  typedef logic [DataWidth-1:0] word_t;

  typedef enum logic [OpWidth-1:0] {
    OP_AND       = 5'd0,
    OP_EOR       = 5'd1,
    OP_SUB       = 5'd2,
    OP_ADD       = 5'd3,
    OP_ADC       = 5'd4,
    OP_SBC       = 5'd5,
    OP_TST       = 5'd6,
    OP_CMP       = 5'd7,
    OP_CMN       = 5'd8,
    OP_ORR       = 5'd9,
    OP_MOV       = 5'd10,
    OP_MOV_CLRCV = 5'd11,
    OP_BIC       = 5'd12,
    OP_MVN       = 5'd13,
    OP_NEG       = 5'd14,
    OP_MUL       = 5'd15,
    OP_LSL       = 5'd16,
    OP_LSR       = 5'd17,
    OP_ASR       = 5'd18,
    OP_ROR       = 5'd19
  } op_t;

  localparam word_t SignMask = 32'h8000_0000;
  localparam word_t AllOnes  = 32'hFFFF_FFFF;
  localparam logic [4:0] RotMask = 5'h1F;

endpackage

// ===== sv/thumb_alu_with_shifter.sv =====
// ----------------------------------------------------------------------------
// thumb_alu_with_shifter
// Thumb data-processing execute unit: logic, add/subtract, multiply and
// barrel shifts with ARM flag rules, one request per clock.
// ----------------------------------------------------------------------------
// result path: a request passes the input register, then the result register, and its
//   result shows with done high for one cycle
// throughput: one request per clock; busy stays low, the receiver cannot stall
// the critical path is the 32x32 low-word multiplier feeding the result mux
// reset: synchronous active-high rst clears the input and result valid bits
module thumb_alu_with_shifter (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  op,
  input  logic [31:0] operand_n,
  input  logic [31:0] operand_m,
  input  logic [7:0]  shift_amount,
  input  logic        carry_in,
  input  logic        overflow_in,
  // result side
  output logic        done,
  output logic [31:0] result,
  output logic        write_result,
  output logic        flag_n,
  output logic        flag_z,
  output logic        flag_c,
  output logic        flag_v
);

  // no multi-cycle work, so a request is taken every cycle
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic        ex_valid;
  logic [4:0]  ex_op;
  logic [31:0] ex_n;
  logic [31:0] ex_m;
  logic [7:0]  ex_sa;
  logic        ex_c;
  logic        ex_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else begin
      ex_valid <= start && !busy;
    end
  end

  // payload only, captured on every request
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      ex_op <= op;
      ex_n  <= operand_n;
      ex_m  <= operand_m;
      ex_sa <= shift_amount;
      ex_c  <= carry_in;
      ex_v  <= overflow_in;
    end
  end

  // --------------------------------------------------------------------------
  // shared adder: sub-type ops invert m, neg forces the first input to zero
  // --------------------------------------------------------------------------
  logic        add_inv_m;
  logic        add_zero_a;
  logic        add_cin;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic [32:0] add_sum;
  logic        add_c;
  logic        add_v;

  always_comb begin
    add_inv_m  = 1'b0;
    add_zero_a = 1'b0;
    add_cin    = 1'b0;
    case (ex_op)
      talu_pkg::OP_SUB, talu_pkg::OP_CMP: begin
        add_inv_m = 1'b1;
        add_cin   = 1'b1;
      end
      talu_pkg::OP_SBC: begin
        add_inv_m = 1'b1;
        add_cin   = ex_c;
      end
      talu_pkg::OP_ADC: begin
        add_cin = ex_c;
      end
      talu_pkg::OP_NEG: begin
        add_inv_m  = 1'b1;
        add_zero_a = 1'b1;
        add_cin    = 1'b1;
      end
      default: begin
        add_inv_m = 1'b0;
      end
    endcase
  end

  assign add_a   = add_zero_a ? '0 : ex_n;
  assign add_b   = add_inv_m ? ~ex_m : ex_m;
  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
  assign add_c   = add_sum[32];
  // signed overflow: operands agree in sign and the sum does not
  assign add_v   = ~(add_a[31] ^ add_b[31]) & (add_a[31] ^ add_sum[31]);

  // --------------------------------------------------------------------------
  // multiplier, low word only
  // --------------------------------------------------------------------------
  logic [31:0] mul_lo;
  assign mul_lo = ex_n * ex_m;

  // --------------------------------------------------------------------------
  // barrel shifter on m; the carry is the last bit shifted out
  // --------------------------------------------------------------------------
  logic              sa_zero;
  logic              sa_ge32;
  logic              sa_eq32;
  logic [4:0]        sa_lo;
  logic [32:0]       lsl_ext;
  logic [32:0]       lsr_ext;
  logic signed [32:0] asr_ext;
  logic [63:0]       ror_ext;
  logic [31:0]       shf_res;
  logic              shf_c;

  assign sa_zero = (ex_sa == 8'd0);
  assign sa_ge32 = (ex_sa[7:5] != 3'd0);
  assign sa_eq32 = (ex_sa == 8'd32);
  assign sa_lo   = ex_sa[4:0] & talu_pkg::RotMask;

  // extra bit below or above the word catches the shifted-out bit
  assign lsl_ext = {1'b0, ex_m} << sa_lo;
  assign lsr_ext = {ex_m, 1'b0} >> sa_lo;
  assign asr_ext = $signed({ex_m, 1'b0}) >>> sa_lo;
  assign ror_ext = {ex_m, ex_m} >> sa_lo;

  always_comb begin
    shf_res = ex_m;
    shf_c   = ex_c;
    if (!sa_zero) begin
      case (ex_op)
        talu_pkg::OP_LSL: begin
          if (sa_ge32) begin
            shf_res = '0;
            shf_c   = sa_eq32 & ex_m[0];
          end else begin
            shf_res = lsl_ext[31:0];
            shf_c   = lsl_ext[32];
          end
        end
        talu_pkg::OP_LSR: begin
          if (sa_ge32) begin
            shf_res = '0;
            shf_c   = sa_eq32 & ex_m[31];
          end else begin
            shf_res = lsr_ext[32:1];
            shf_c   = lsr_ext[0];
          end
        end
        talu_pkg::OP_ASR: begin
          if (sa_ge32) begin
            shf_res = ex_m[31] ? talu_pkg::AllOnes : '0;
            shf_c   = ex_m[31];
          end else begin
            shf_res = asr_ext[32:1];
            shf_c   = asr_ext[0];
          end
        end
        default: begin
          // ror: a multiple of 32 keeps the word, carry is bit 31 either way
          shf_res = ror_ext[31:0];
          shf_c   = ror_ext[31];
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // result select and flags
  // --------------------------------------------------------------------------
  logic [31:0] result_next;
  logic        write_next;
  logic        c_next;
  logic        v_next;

  always_comb begin
    result_next = '0;
    write_next  = 1'b1;
    c_next      = ex_c;
    v_next      = ex_v;
    unique case (ex_op)
      talu_pkg::OP_AND: result_next = ex_n & ex_m;
      talu_pkg::OP_EOR: result_next = ex_n ^ ex_m;
      talu_pkg::OP_ORR: result_next = ex_n | ex_m;
      talu_pkg::OP_BIC: result_next = ex_n & ~ex_m;
      talu_pkg::OP_MVN: result_next = ~ex_m;
      talu_pkg::OP_MOV: result_next = ex_m;
      talu_pkg::OP_MUL: result_next = mul_lo;
      talu_pkg::OP_TST: begin
        result_next = ex_n & ex_m;
        write_next  = 1'b0;
      end
      talu_pkg::OP_MOV_CLRCV: begin
        result_next = ex_m;
        c_next      = 1'b0;
        v_next      = 1'b0;
      end
      talu_pkg::OP_SUB, talu_pkg::OP_ADD, talu_pkg::OP_ADC,
      talu_pkg::OP_SBC, talu_pkg::OP_NEG: begin
        result_next = add_sum[31:0];
        c_next      = add_c;
        v_next      = add_v;
      end
      talu_pkg::OP_CMP, talu_pkg::OP_CMN: begin
        result_next = add_sum[31:0];
        write_next  = 1'b0;
        c_next      = add_c;
        v_next      = add_v;
      end
      talu_pkg::OP_LSL, talu_pkg::OP_LSR,
      talu_pkg::OP_ASR, talu_pkg::OP_ROR: begin
        result_next = shf_res;
        c_next      = shf_c;
      end
      default: begin
        // undefined op codes: zero result, no write back, carry and overflow flags pass through
        result_next = '0;
        write_next  = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // result register, one-cycle strobe
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ex_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_valid) begin
      result       <= result_next;
      write_result <= write_next;
      flag_n       <= result_next[31];
      flag_z       <= (result_next == '0);
      flag_c       <= c_next;
      flag_v       <= v_next;
    end
  end

endmodule

// ===== sv/talu_checker.sv =====
// ----------------------------------------------------------------------------
// talu_checker
// Port-level checks on timing and flag consistency of the thumb ALU.
// ----------------------------------------------------------------------------
module talu_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [4:0]  op,
  input logic        done,
  input logic [31:0] result,
  input logic        write_result,
  input logic        flag_n,
  input logic        flag_z
);

  // a request always gives its result with done, through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("request without result two cycles later");

  // no result without a request that passed through the input and result registers
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result strobe without request");

  // compare and test ops never write back
  a_compare_no_write: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == talu_pkg::OP_TST || op == talu_pkg::OP_CMP ||
                        op == talu_pkg::OP_CMN)) |-> ##2 (done && !write_result))
    else $error("compare op wrote back");

  // n and z follow the result value
  a_nz_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> (flag_n == result[31]) && (flag_z == (result == 32'd0)))
    else $error("n or z flag disagrees with result");

endmodule

bind thumb_alu_with_shifter talu_checker u_talu_checker (.*);
